FILE: hw/rtl/phb_pkg.sv
// ----------------------------------------------------------------------------
// phb_pkg: shared types and constants of the Potts heat-bath site updater
// Configuration register widths, codes and the configuration bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phb_pkg;

   localparam int NUM_STATES_W = 5;
   localparam int SIDE_W       = 7;
   localparam int WEIGHT_W     = 48;
   localparam int NUM_WEIGHTS  = 4;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;

   // Weight for a neighbor count of zero: 1.0 with 16 fraction bits
   localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY = 48'd65536;

   // Kind of a request item
   typedef enum logic {
      KIND_UPDATE = 1'b0,
      KIND_READ   = 1'b1
   } site_kind_type;

   // Register indexes, one per 8-byte slot
   typedef enum logic [2:0] {
      REG_NUM_STATES  = 3'd0,
      REG_SIDE_LENGTH = 3'd1,
      REG_WEIGHT_ONE  = 3'd2,
      REG_WEIGHT_TWO  = 3'd3,
      REG_WEIGHT_THR  = 3'd4,
      REG_WEIGHT_FOUR = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [NUM_STATES_W-1:0]               num_states;
      logic [SIDE_W-1:0]                     side_length;
      logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0]  weight;   // weight[n-1] for a count of n
   } cfg_type;

endpackage

FILE: hw/rtl/potts_heat_bath_site_update_top.sv
// ----------------------------------------------------------------------------
// potts_heat_bath_site_update_top: heat-bath update of a q-state Potts lattice
// Update item: fetches the four neighbors, sums the weights of states 1..q, forms
// u * total and scans up to the chosen state k (1..q); read item: fetches the site.
// One item at a time, accepted only in ST_IDLE; the time per item is set by the
// single read port of the lattice memory and the per-state scans.
// Reset: synchronous; a clearing pass writes state 1 to all MAX_SIDE*MAX_SIDE
// sites, no item is accepted meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module potts_heat_bath_site_update_top #(
   parameter int MAX_SIDE   = 64,
   parameter int MAX_STATES = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   // Update / read items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,   // row[5:0], col[11:6],
                                                            // random_fraction[43:12], zero pad
   input  logic [0:0]                          req_tuser,   // kind (0 update, 1 read)

   // Results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // site_state[4:0],
                                                            // site_row[10:5], site_col[16:11], zero pad

   // Configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [phb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [phb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [phb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // ------------------------------------------------------------------------
   // Derived sizes
   // ------------------------------------------------------------------------
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);                 // lattice address
   localparam int CW    = $clog2(MAX_SIDE);              // one coordinate
   localparam int ESW   = ($clog2(MAX_SIDE + 1) > phb_pkg::SIDE_W) ?
                          $clog2(MAX_SIDE + 1) : phb_pkg::SIDE_W;  // clamped side
   localparam int RDW   = ESW + 6;                       // modulo reduction compare
   localparam int CDW   = (MAX_STATES > 2) ? $clog2(MAX_STATES) : 1;  // stored code
   localparam int QW    = ($clog2(MAX_STATES + 1) > phb_pkg::NUM_STATES_W) ?
                          $clog2(MAX_STATES + 1) : phb_pkg::NUM_STATES_W;
   localparam int TW    = phb_pkg::WEIGHT_W + $clog2(MAX_STATES);  // total weight
   localparam int PW    = TW + 32;                       // u * total

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_FETCH,
      ST_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_ADD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   phb_pkg::cfg_type cfg;

   phb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type              state_ff;
   logic [AW-1:0]          clr_ff;
   phb_pkg::site_kind_type kind_ff;
   logic [5:0]        row_ff;          // reduced in place during ST_REDUCE
   logic [5:0]        col_ff;
   logic [31:0]       u_ff;
   logic [2:0]        red_ff;          // shift of the side in the reduction step
   logic [2:0]        idx_ff;          // memory fetch slot
   logic [CDW-1:0]    nb_ff [4];       // left, right, up, down codes
   logic [QW-1:0]     s_ff;            // candidate state
   logic [TW-1:0]     total_ff;
   logic [TW-1:0]     cum_ff;
   logic [63:0]       p0_ff;
   logic [TW-1:0]     p1_ff;
   logic [PW-1:0]     prod_ff;
   logic [QW-1:0]     result_ff;
   logic              rsp_valid_ff;
   logic [23:0]       rsp_data_ff;

   logic [CDW-1:0]    lattice_ff [DEPTH];
   logic [CDW-1:0]    rd_data_ff;

   // ------------------------------------------------------------------------
   // Effective configuration: clamp q and L to their legal ranges
   // ------------------------------------------------------------------------
   logic [ESW-1:0]    eff_side;
   logic [QW-1:0]     eff_q;

   always_comb begin
      if (ESW'(cfg.side_length) < ESW'(2)) begin
         eff_side = ESW'(2);
      end else if (ESW'(cfg.side_length) > ESW'(MAX_SIDE)) begin
         eff_side = ESW'(MAX_SIDE);
      end else begin
         eff_side = ESW'(cfg.side_length);
      end
      if (QW'(cfg.num_states) < QW'(2)) begin
         eff_q = QW'(2);
      end else if (QW'(cfg.num_states) > QW'(MAX_STATES)) begin
         eff_q = QW'(MAX_STATES);
      end else begin
         eff_q = QW'(cfg.num_states);
      end
   end

   // ------------------------------------------------------------------------
   // Modulo reduction: restoring remainder, one shifted side per cycle
   // ------------------------------------------------------------------------
   function automatic logic [5:0] reduce_step(input logic [5:0]     rem,
                                              input logic [ESW-1:0] side,
                                              input logic [2:0]     k);
      logic [RDW-1:0] shifted;
      logic [RDW-1:0] ext;
      shifted = RDW'(side) << k;
      ext     = RDW'(rem);
      if (ext >= shifted) begin
         return 6'(ext - shifted);
      end
      return rem;
   endfunction

   logic [5:0] row_in;
   logic [5:0] col_in;

   assign row_in = reduce_step(row_ff, eff_side, red_ff);
   assign col_in = reduce_step(col_ff, eff_side, red_ff);

   // ------------------------------------------------------------------------
   // Site and neighbor addresses with periodic wrap
   // ------------------------------------------------------------------------
   function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_SIDE) + AW'(c);
   endfunction

   logic [CW-1:0] r_c;
   logic [CW-1:0] c_c;
   logic [CW-1:0] side_last;
   logic [CW-1:0] c_left;
   logic [CW-1:0] c_right;
   logic [CW-1:0] r_up;
   logic [CW-1:0] r_down;
   logic [AW-1:0] center_addr;
   logic [AW-1:0] rd_addr;

   always_comb begin
      r_c       = CW'(row_ff);
      c_c       = CW'(col_ff);
      side_last = CW'(eff_side - ESW'(1));
      c_left    = (c_c == '0) ? side_last : c_c - CW'(1);
      c_right   = (c_c == side_last) ? '0 : c_c + CW'(1);
      r_up      = (r_c == '0) ? side_last : r_c - CW'(1);
      r_down    = (r_c == side_last) ? '0 : r_c + CW'(1);
      center_addr = site_addr(r_c, c_c);
      case (idx_ff)
         3'd0:    rd_addr = (kind_ff == phb_pkg::KIND_READ) ? center_addr
                                                             : site_addr(r_c, c_left);
         3'd1:    rd_addr = site_addr(r_c, c_right);
         3'd2:    rd_addr = site_addr(r_up, c_c);
         default: rd_addr = site_addr(r_down, c_c);
      endcase
   end

   // ------------------------------------------------------------------------
   // Weight of the current candidate: count matching neighbors, look up W[n].
   // A neighbor left over from a larger q never equals a candidate <= q.
   // ------------------------------------------------------------------------
   function automatic logic [phb_pkg::WEIGHT_W-1:0] weight_for(input logic [2:0] n,
                                                               input phb_pkg::cfg_type c);
      case (n)
         3'd1:    return c.weight[0];
         3'd2:    return c.weight[1];
         3'd3:    return c.weight[2];
         3'd4:    return c.weight[3];
         default: return phb_pkg::WEIGHT_UNITY;
      endcase
   endfunction

   logic [2:0]                   match_cnt;
   logic [phb_pkg::WEIGHT_W-1:0] w_s;
   logic [TW-1:0]                cum_in;
   logic                         scan_done;

   always_comb begin
      match_cnt = '0;
      for (int k = 0; k < 4; k++) begin
         if (QW'(nb_ff[k]) + QW'(1) == s_ff) begin
            match_cnt = match_cnt + 3'd1;
         end
      end
      w_s    = weight_for(match_cnt, cfg);
      cum_in = cum_ff + TW'(w_s);
      // Stop at the first state with C_s * 2^32 >= u * total, else at q
      scan_done = ({cum_in, 32'd0} >= prod_ff) || (s_ff == eff_q);
   end

   // ------------------------------------------------------------------------
   // Lattice memory: one write port, one registered read port.
   // The write of an update lands in ST_SCAN; the next item spends its
   // reduction cycles before any read, so no forwarding is needed.
   // ------------------------------------------------------------------------
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [CDW-1:0] mem_wdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = center_addr;
      mem_wdata = CDW'(s_ff - QW'(1));
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_SCAN && scan_done) begin
         mem_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lattice_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= lattice_ff[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken; ST_FINISH refills it itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= phb_pkg::site_kind_type'(req_tuser[0]);
                  row_ff   <= req_tdata[5:0];
                  col_ff   <= req_tdata[11:6];
                  u_ff     <= req_tdata[43:12];
                  red_ff   <= 3'd5;
                  state_ff <= ST_REDUCE;
               end
            end

            // Reduce row and column modulo the side, largest shift first
            ST_REDUCE: begin
               row_ff <= row_in;
               col_ff <= col_in;
               red_ff <= red_ff - 3'd1;
               if (red_ff == 3'd0) begin
                  idx_ff   <= 3'd0;
                  state_ff <= ST_FETCH;
               end
            end

            // Issue one read per cycle; the registered read data arrives in the next cycle
            ST_FETCH: begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff != 3'd0) begin
                  nb_ff[2'(idx_ff - 3'd1)] <= rd_data_ff;
               end
               if (kind_ff == phb_pkg::KIND_READ && idx_ff == 3'd1) begin
                  result_ff <= QW'(rd_data_ff) + QW'(1);
                  state_ff  <= ST_FINISH;
               end else if (idx_ff == 3'd4) begin
                  s_ff     <= QW'(1);
                  total_ff <= '0;
                  state_ff <= ST_SUM;
               end
            end

            // Accumulate the total weight over states 1..q
            ST_SUM: begin
               total_ff <= total_ff + TW'(w_s);
               if (s_ff == eff_q) begin
                  state_ff <= ST_MUL_LO;
               end else begin
                  s_ff <= s_ff + QW'(1);
               end
            end

            // u * total in two partial products and a final add
            ST_MUL_LO: begin
               p0_ff    <= 64'(u_ff) * 64'(total_ff[31:0]);
               state_ff <= ST_MUL_HI;
            end

            ST_MUL_HI: begin
               p1_ff    <= TW'(u_ff) * TW'(total_ff[TW-1:32]);
               state_ff <= ST_MUL_ADD;
            end

            ST_MUL_ADD: begin
               prod_ff  <= PW'(p0_ff) + (PW'(p1_ff) << 32);
               s_ff     <= QW'(1);
               cum_ff   <= '0;
               state_ff <= ST_SCAN;
            end

            // Walk the cumulative weight until it reaches u * total
            ST_SCAN: begin
               cum_ff <= cum_in;
               if (scan_done) begin
                  result_ff <= s_ff;
                  state_ff  <= ST_FINISH;
               end else begin
                  s_ff <= s_ff + QW'(1);
               end
            end

            // Hold until the output register is free
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'd0, col_ff, row_ff, 5'(result_ff)};
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/phb_csr.sv
// ----------------------------------------------------------------------------
// phb_csr: configuration register block
// APB-style register file, 64-bit data, registers at 8-byte strides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [phb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [phb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [phb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output phb_pkg::cfg_type                    cfg
);

   phb_pkg::cfg_type cfg_ff;
   logic [2:0]       reg_index;
   logic             wr_en;

   assign reg_index  = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_states  <= 5'd2;
         cfg_ff.side_length <= 7'd64;
         cfg_ff.weight      <= {phb_pkg::NUM_WEIGHTS{phb_pkg::WEIGHT_UNITY}};
      end else if (wr_en) begin
         unique case (reg_index)
            phb_pkg::REG_NUM_STATES:
               cfg_ff.num_states  <= csr_pwdata[phb_pkg::NUM_STATES_W-1:0];
            phb_pkg::REG_SIDE_LENGTH:
               cfg_ff.side_length <= csr_pwdata[phb_pkg::SIDE_W-1:0];
            phb_pkg::REG_WEIGHT_ONE:
               cfg_ff.weight[0]   <= csr_pwdata[phb_pkg::WEIGHT_W-1:0];
            phb_pkg::REG_WEIGHT_TWO:
               cfg_ff.weight[1]   <= csr_pwdata[phb_pkg::WEIGHT_W-1:0];
            phb_pkg::REG_WEIGHT_THR:
               cfg_ff.weight[2]   <= csr_pwdata[phb_pkg::WEIGHT_W-1:0];
            phb_pkg::REG_WEIGHT_FOUR:
               cfg_ff.weight[3]   <= csr_pwdata[phb_pkg::WEIGHT_W-1:0];
            default: ;  // drop writes to unmapped addresses
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         phb_pkg::REG_NUM_STATES:  csr_prdata = 64'(cfg_ff.num_states);
         phb_pkg::REG_SIDE_LENGTH: csr_prdata = 64'(cfg_ff.side_length);
         phb_pkg::REG_WEIGHT_ONE:  csr_prdata = 64'(cfg_ff.weight[0]);
         phb_pkg::REG_WEIGHT_TWO:  csr_prdata = 64'(cfg_ff.weight[1]);
         phb_pkg::REG_WEIGHT_THR:  csr_prdata = 64'(cfg_ff.weight[2]);
         phb_pkg::REG_WEIGHT_FOUR: csr_prdata = 64'(cfg_ff.weight[3]);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule
